### sv/llqm_pkg.sv
// Shared types and constants for the linked-list queue manager.
// Used by the RAM-backed datapath, the controller, the top level and the checker.
`default_nettype none

package llqm_pkg;

    localparam int NODES_DEFAULT = 16;
    localparam int IDX_W         = 4;
    localparam int OPC_W         = 3;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 8;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK,
        ST_READ
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic link_wr;   // push back: link old tail to the new node
        logic rd_issue;  // start a next-table read
        logic finish;    // apply the operation and load the result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic skip;       // slot out of range, operation ignored
        logic head_none;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### sv/llqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module llqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/llqm_dp.sv
// Datapath: head/tail registers, command capture, next-pointer RAM and result register.
// Depends on llqm_pkg and llqm_ram.
`default_nettype none

module llqm_dp #(
    parameter int NODES = llqm_pkg::NODES_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [llqm_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic      [llqm_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire llqm_pkg::dp_cmd_t                   cmd,
    output llqm_pkg::dp_stat_t                       stat
);

    import llqm_pkg::*;

    localparam int PW    = $clog2(NODES + 1);
    localparam int AW    = $clog2(NODES);
    localparam int CMP_W = ((PW > IDX_W) ? PW : IDX_W) + 1;
    localparam logic [PW-1:0]    NONE      = PW'(NODES);
    localparam logic [CMP_W-1:0] NODES_CMP = CMP_W'(NODES);

    // captured command
    op_t              op_reg;
    logic [IDX_W-1:0] node_reg;
    logic [IDX_W-1:0] pred_reg;
    logic             pp_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [CMP_W-1:0] node_ext, pred_ext, head_ext;
    logic             node_ok, pred_ok;
    logic [PW-1:0]    node_ptr, pred_ptr;
    logic [AW-1:0]    node_addr, pred_addr;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [PW-1:0]    wdata;
    logic [AW-1:0]    raddr;
    logic [PW-1:0]    rdata;

    logic             pop_valid;
    logic [IDX_W-1:0] pop_node;
    logic             out_free;

    assign node_ext  = CMP_W'(node_reg);
    assign pred_ext  = CMP_W'(pred_reg);
    assign head_ext  = CMP_W'(head_reg);
    assign node_ok   = node_ext < NODES_CMP;
    assign pred_ok   = pred_ext < NODES_CMP;
    assign node_ptr  = node_ext[PW-1:0];
    assign pred_ptr  = pred_ext[PW-1:0];
    assign node_addr = node_ext[AW-1:0];
    assign pred_addr = pred_ext[AW-1:0];

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        stat.op        = op_reg;
        stat.skip      = !node_ok || ((op_reg == OP_REMOVE) && pp_reg && !pred_ok);
        stat.head_none = (head_reg == NONE);
        stat.out_free  = out_free;
    end

    // read the successor of the head for a pop, of the node for a remove
    assign raddr = (op_reg == OP_POP_FRONT) ? head_reg[AW-1:0] : node_addr;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        we        = 1'b0;
        waddr     = node_addr;
        wdata     = NONE;
        pop_valid = 1'b0;
        pop_node  = '0;

        if (cmd.link_wr)
        begin
            // skip the link when the queue is empty or the tail went stale
            we    = (head_reg != NONE) && (tail_reg < NONE);
            waddr = tail_reg[AW-1:0];
            wdata = node_ptr;
        end
        else if (cmd.finish)
        begin
            case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (!stat.skip)
                    begin
                        we        = 1'b1;
                        waddr     = node_addr;
                        wdata     = head_reg;
                        head_next = node_ptr;
                        if (head_reg == NONE)
                        begin
                            tail_next = node_ptr;
                        end
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (!stat.skip)
                    begin
                        if (head_reg == NONE)
                        begin
                            head_next = node_ptr;
                        end
                        we        = 1'b1;
                        waddr     = node_addr;
                        wdata     = NONE;
                        tail_next = node_ptr;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (head_reg != NONE)
                    begin
                        pop_valid = 1'b1;
                        pop_node  = head_ext[IDX_W-1:0];
                        head_next = rdata;
                    end
                end
                OP_REMOVE:
                begin
                    if (!stat.skip)
                    begin
                        if (!pp_reg)
                        begin
                            head_next = rdata;
                        end
                        else if (rdata == NONE)
                        begin
                            we        = 1'b1;
                            waddr     = pred_addr;
                            wdata     = NONE;
                            tail_next = pred_ptr;
                        end
                        else
                        begin
                            we    = 1'b1;
                            waddr = pred_addr;
                            wdata = rdata;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    head_next = NONE;
                    tail_next = NONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NONE;
            tail_reg      <= NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(s_tdata[2:0]);
            node_reg <= s_tdata[6:3];
            pred_reg <= s_tdata[10:7];
            pp_reg   <= s_tdata[11];
        end
        if (cmd.finish)
        begin
            out_data_reg <= {2'b00, (head_next == NONE), pop_valid, pop_node};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    llqm_ram #(
        .WIDTH (PW),
        .DEPTH (NODES)
    ) u_next_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_issue),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

### sv/llqm_ctrl.sv
// Controller state machine: sequences capture, link write, table read and finish.
// Depends on llqm_pkg.
`default_nettype none

module llqm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire llqm_pkg::dp_stat_t  stat,
    output llqm_pkg::dp_cmd_t        cmd
);

    import llqm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((stat.op == OP_PUSH_BACK) && !stat.skip)
                begin
                    cmd.link_wr = 1'b1;
                    state_next  = ST_LINK;
                end
                else if (((stat.op == OP_POP_FRONT) && !stat.head_none) ||
                         ((stat.op == OP_REMOVE) && !stat.skip))
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_READ;
                end
                else if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LINK, ST_READ:
            begin
                // hold until the result register can take the beat
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/linked_list_queue_manager.sv
// Each beat is captured in IDLE; EXEC finishes push front, clear, ignored items and pop on
// empty, while push back goes on through LINK (single write port) and pop and remove through
// READ (registered read of the next-pointer RAM). Finish waits for a free result register; a new
// item is taken only back in IDLE. A waiting result does not block the next input beat.
// Reset (rst_n low, async): head and tail become none, no result pending; the
// next-pointer RAM is not cleared and holds undefined data until written.
// Top level; depends on llqm_pkg, llqm_ctrl, llqm_dp and llqm_ram.
`default_nettype none

module linked_list_queue_manager #(
    parameter int NODES = llqm_pkg::NODES_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // s_tdata: opcode[2:0], node_index[6:3], pred_index[10:7], pred_present[11], zero[15:12]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [llqm_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: popped_node[3:0], popped_valid[4], queue_empty[5], zero[7:6]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [llqm_pkg::M_TDATA_W-1:0]  m_tdata
);

    import llqm_pkg::*;

    // Controller and datapath talk only through these two groups.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: accept in IDLE, then one or two more steps per item.
    llqm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: head/tail, next-pointer RAM, result register.
    llqm_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

### sv/llqm_checker.sv
// Port-level checker for the linked-list queue manager, bound to the top level.
// Depends on llqm_pkg.
`default_nettype none

module llqm_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [llqm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [llqm_pkg::M_TDATA_W-1:0]  m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input beat changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // a result without popped valid reports node zero
    a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> m_tdata[3:0] == 4'd0)
        else $error("popped node nonzero without popped valid");

    // a rising result is never directly preceded by an accept
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared the cycle after accept");

endmodule

bind linked_list_queue_manager llqm_checker u_llqm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
